[src/mie_pkg.sv]
// Shared types and constants for the modular inverse core.
// No dependencies.
package mie_pkg;

	localparam int MOD_W = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_FIX,
		ST_CHECK,
		ST_DIV,
		ST_UPD,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

[src/modular_inverse_ext_euclid_core.sv]
// Modular inverse core: signed reduction and extended Euclid with bit-serial division.
// Depends on mie_pkg.
//
// channel  dir  fields
// s_axis   in   tdata: value
// m_axis   out  tdata: inverse[30:0], status[31]
// cfg      in   modulus (31 bits)
//
// Each request first reduces the value with a restoring divider, one quotient bit per
// cycle. Every Euclid step then runs the same divider, while the quotient times the
// coefficient builds up by shift and add. Each step also passes through a check and
// an update state. The number of steps depends on the data (at most about 45 for
// 31-bit moduli). Reset puts the control in idle; the modulus resets to 26.
// A result waiting on m_axis_tready holds the block; the next request is taken once
// the result is delivered.
module modular_inverse_ext_euclid_core #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [30:0]           cfg_wdata,      // modulus
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // value
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata    // inverse[30:0], status[31]
);
	import mie_pkg::*;

	localparam int CW = (DATA_WIDTH > MOD_W) ? DATA_WIDTH : MOD_W;
	localparam int BW = $clog2(CW + 1);

	state_t state_q, state_d;
	logic [MOD_W-1:0] mod_q;
	// Divider: dividend shifts out through num_q while remainder builds in rem_q.
	logic [CW-1:0] num_q;
	logic [MOD_W:0] rem_q;
	logic [MOD_W-1:0] den_q;
	logic [BW-1:0] cnt_q;
	logic neg_q;
	// Euclid state; coefficients kept as magnitudes with signs, they alternate.
	logic [MOD_W-1:0] r_q, nr_q, t_q, nt_q;
	logic [MOD_W-1:0] prod_q;
	logic tneg_q;
	logic [MOD_W-1:0] res_q;
	logic stat_q;

	logic [MOD_W:0] trial;
	logic [MOD_W+1:0] diff;
	logic [DATA_WIDTH-1:0] mag;

	assign mag = s_axis_tdata[DATA_WIDTH-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
	assign trial = {rem_q[MOD_W-1:0], num_q[CW-1]};
	assign diff = {1'b0, trial} - {2'b0, den_q};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {stat_q, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_W'(26);
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_RED;
			ST_RED: if (cnt_q == BW'(1)) state_d = ST_FIX;
			ST_FIX: state_d = ST_CHECK;
			ST_CHECK: state_d = (nr_q == '0) ? ST_FIN : ST_DIV;
			ST_DIV: if (cnt_q == BW'(1)) state_d = ST_UPD;
			ST_UPD: state_d = ST_CHECK;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Quotient bits arrive MSB first, so prod_q doubles and adds nt_q for each set bit.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q <= CW'(mag) << (CW - DATA_WIDTH);
				neg_q <= s_axis_tdata[DATA_WIDTH-1];
				rem_q <= '0;
				den_q <= mod_q;
				cnt_q <= BW'(DATA_WIDTH);
			end
			ST_RED, ST_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				if (!diff[MOD_W+1]) begin
					rem_q <= diff[MOD_W:0];
					num_q <= {num_q[CW-2:0], 1'b1};
					prod_q <= {prod_q[MOD_W-2:0], 1'b0} + nt_q;
				end else begin
					rem_q <= trial;
					num_q <= {num_q[CW-2:0], 1'b0};
					prod_q <= {prod_q[MOD_W-2:0], 1'b0};
				end
			end
			ST_FIX: begin
				r_q <= mod_q;
				nr_q <= (neg_q && rem_q != '0) ? (mod_q - rem_q[MOD_W-1:0]) :
					rem_q[MOD_W-1:0];
				t_q <= '0;
				nt_q <= MOD_W'(1);
				tneg_q <= 1'b0;
			end
			ST_CHECK: begin
				num_q <= CW'(r_q) << (CW - MOD_W);
				den_q <= nr_q;
				rem_q <= '0;
				prod_q <= '0;
				cnt_q <= BW'(MOD_W);
			end
			ST_UPD: begin
				// |new t| = |t| + q*|nt| since signs alternate; bounded by the modulus.
				nt_q <= t_q + prod_q;
				t_q <= nt_q;
				tneg_q <= ~tneg_q;
				r_q <= nr_q;
				nr_q <= rem_q[MOD_W-1:0];
			end
			ST_FIN: begin
				// tneg_q is the sign of nt_q, so t_q carries the opposite sign.
				if (mod_q == MOD_W'(1)) begin
					res_q <= '0;
					stat_q <= 1'b0;
				end else if (r_q != MOD_W'(1)) begin
					res_q <= '0;
					stat_q <= 1'b1;
				end else begin
					res_q <= (!tneg_q && t_q != '0) ? (mod_q - t_q) : t_q;
					stat_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[dv/tb_modular_inverse_ext_euclid_core.sv]
// Self-checking testbench for modular_inverse_ext_euclid_core: drives value requests and
// modulus writes, predicts each inverse and status, and compares them with the results.
// Depends on mie_pkg and modular_inverse_ext_euclid_core.
`timescale 1ns / 100ps

class inverse_scoreboard;
	typedef struct {
		logic [30:0] inverse;
		logic        status;
	} inverse_result_t;

	inverse_result_t expected_results[$];
	int unsigned     error_count;
	int unsigned     checked_count;

	// Extended Euclid on (modulus, reduced value), tracking only the value's coefficient.
	static function inverse_result_t predict_inverse(logic signed [31:0] value,
			logic [30:0] modulus);
		inverse_result_t res;
		longint m, t, new_t, r, new_r, q, tt, rr;
		m = longint'(modulus);
		res.inverse = '0;
		res.status = 1'b1;
		if (m == 0)
			return res;
		new_r = longint'(value) % m;
		if (new_r < 0)
			new_r += m;
		t = 0;
		new_t = 1;
		r = m;
		while (new_r != 0) begin
			q = r / new_r;
			tt = t - q * new_t;
			rr = r - q * new_r;
			t = new_t;
			new_t = tt;
			r = new_r;
			new_r = rr;
		end
		if (r > 1)
			return res;
		t = t % m;
		if (t < 0)
			t += m;
		res.inverse = t[30:0];
		res.status = 1'b0;
		return res;
	endfunction

	function void note_request(logic signed [31:0] value, logic [30:0] modulus);
		expected_results.insert(expected_results.size(), predict_inverse(value, modulus));
	endfunction

	function void check_result(logic [31:0] data);
		inverse_result_t exp_res;
		if (expected_results.size() == 0) begin
			$error("unexpected result: tdata=%h", data);
			error_count++;
			return;
		end
		exp_res = expected_results.pop_front();
		checked_count++;
		if (data[30:0] !== exp_res.inverse) begin
			$error("inverse: expected %0d, actual %0d", exp_res.inverse, data[30:0]);
			error_count++;
		end
		if (data[31] !== exp_res.status) begin
			$error("status: expected %0d, actual %0d", exp_res.status, data[31]);
			error_count++;
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb_modular_inverse_ext_euclid_core;
	import mie_pkg::*;

	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int     DRAIN_CYCLES = 1600;
	localparam int     LONG_HOLD_CYCLES = 500;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;     // value
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;     // inverse[30:0], status[31]

	inverse_scoreboard sb;
	logic [30:0]       cur_modulus;
	longint            cycle_count;
	int unsigned       request_count;
	bit                long_hold_pending;

	modular_inverse_ext_euclid_core #(.DATA_WIDTH(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_value(logic [31:0] value);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(value, cur_modulus);
		request_count++;
	endtask

	// Lowers valid and waits until every predicted result has been delivered.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES / 100) @(posedge clk);
	endtask

	task automatic write_modulus(logic [30:0] modulus);
		cfg_we <= 1'b1;
		cfg_wdata <= modulus;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_modulus = modulus;
	endtask

	// Mix of full-range values, small values, multiples of the modulus and their neighbors.
	function automatic logic [31:0] random_value();
		logic [31:0] k;
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 300);
			2: return -$urandom_range(1, 300);
			3: begin
				k = $urandom_range(0, 40);
				return k * cur_modulus + $urandom_range(0, 2) - 1;
			end
			4: return {1'b1, 31'($urandom())};
			default: return {1'b0, 31'($urandom())};
		endcase
	endfunction

	task automatic random_phase(int count);
		repeat (count) send_value(random_value());
		drain();
	endtask

	always begin
		int stall;
		@(posedge clk);
		if (long_hold_pending) begin
			long_hold_pending = 1'b0;
			m_axis_tready <= 1'b0;
			repeat (LONG_HOLD_CYCLES) @(posedge clk);
		end else begin
			stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
		m_axis_tready <= 1'b1;
		do @(posedge clk); while (!m_axis_tvalid);
		sb.check_result(m_axis_tdata);
	end

	initial begin
		logic [31:0] directed_values[$];
		sb = new();
		cycle_count = 0;
		request_count = 0;
		long_hold_pending = 1'b0;
		cur_modulus = 31'd26;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus of 26: zero, unit values, multiples and the value extremes.
		directed_values = '{32'd0, 32'd1, -32'sd1, 32'd13, 32'd25, 32'd26, -32'sd26,
			32'd27, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'd7, 32'hFFFF_FFFF, 32'd2};
		foreach (directed_values[i])
			send_value(directed_values[i]);
		drain();

		// Modulus of one always gives inverse zero with status clear.
		write_modulus(31'd1);
		send_value(32'd0);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		drain();

		write_modulus(31'h7FFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd2);
		send_value(-32'sd2);
		drain();

		// The long receiver hold lets the block back up onto its input.
		long_hold_pending = 1'b1;
		random_phase(200);

		write_modulus(31'h7FFF_FFFE);
		random_phase(150);
		write_modulus(31'd2);
		random_phase(100);
		write_modulus(31'd97);
		random_phase(150);
		write_modulus(31'd65536);
		random_phase(150);
		write_modulus(31'd1);
		random_phase(40);
		repeat (3) begin
			write_modulus(31'($urandom_range(3, 32'h7FFF_FFFF)));
			random_phase(120);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over several moduli from 1 to 2^31-1; %0d results checked.",
			request_count, sb.checked_count);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[modular_inverse_ext_euclid_core.f]
src/mie_pkg.sv
src/modular_inverse_ext_euclid_core.sv
dv/tb_modular_inverse_ext_euclid_core.sv
